// ----- hdl/ihp_pkg.sv -----
package ihp_pkg;

  // action codes
  localparam logic [1:0] ACT_INSERT   = 2'd0;
  localparam logic [1:0] ACT_EXTRACT  = 2'd1;
  localparam logic [1:0] ACT_DECREASE = 2'd2;

  // status codes
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_EMPTY   = 2'd1;
  localparam logic [1:0] STAT_FULL    = 2'd2;
  localparam logic [1:0] STAT_REFUSED = 2'd3;

  localparam int unsigned VERTICES = 256;

  // one heap slot: vertex and its key
  typedef struct packed {
    logic [7:0]  vtx;
    logic [31:0] key;
  } ihp_entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EX_ROOT,
    ST_EX_LAST,
    ST_DN_RDL,
    ST_DN_RDR,
    ST_DN_CMP,
    ST_UP_RD,
    ST_UP_CMP,
    ST_DK_MAP,
    ST_DK_KEY,
    ST_FIN
  } ihp_state_t;

endpackage

// ----- hdl/ihp_ram.sv -----
module ihp_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/indexed_min_heap_top.sv -----
// Indexed binary min-heap with decrease-key, one command at a time.
// A refused command reports straight from idle; a decrease-key is also refused on its key
// after the map and key reads. Insert walks up, swapping with each larger parent;
// decrease-key reads the map and key first, then walks up; extract reads root and last slot,
// then walks down. The next command can be accepted in the cycle its result is shown.
// Synchronous active-low reset empties the heap; no clearing pass is needed.
module indexed_min_heap_top #(
  parameter int CAPACITY = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_vertex,
  input  logic [31:0] in_key,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [7:0]  out_vertex,
  output logic [31:0] out_key,
  output logic [8:0]  out_count
);

  localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = SW + 2;
  localparam int EW = $bits(ihp_pkg::ihp_entry_t);

  ihp_pkg::ihp_state_t state_r, state_nxt;

  logic [CW-1:0]   count_r, count_nxt;
  logic [255:0]    present_r, present_nxt;
  logic [SW-1:0]   pos_r, pos_nxt;
  logic [7:0]      mv_r, mv_nxt;
  logic [31:0]     mk_r, mk_nxt;
  logic [7:0]      rv_r, rv_nxt;
  logic [31:0]     rk_r, rk_nxt;
  logic [7:0]      dv_r, dv_nxt;
  logic [31:0]     dk_r, dk_nxt;
  ihp_pkg::ihp_entry_t left_r, left_nxt;

  logic            ov_r, ov_nxt;
  logic [1:0]      os_r, os_nxt;
  logic [7:0]      ovx_r, ovx_nxt;
  logic [31:0]     okey_r, okey_nxt;
  logic [8:0]      ocnt_r, ocnt_nxt;

  // memory ports
  logic                h_we;
  logic [SW-1:0]       h_waddr, h_raddr;
  ihp_pkg::ihp_entry_t h_wdata, h_rdata;
  logic [EW-1:0]       h_rbits;
  logic                m_we;
  logic [7:0]          m_waddr, m_raddr;
  logic [SW-1:0]       m_wdata, m_rdata;

  ihp_ram #(.DEPTH(CAPACITY), .WIDTH(EW)) u_heap (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
    .raddr(h_raddr), .rdata(h_rbits)
  );
  assign h_rdata = ihp_pkg::ihp_entry_t'(h_rbits);

  ihp_ram #(.DEPTH(ihp_pkg::VERTICES), .WIDTH(SW)) u_map (
    .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
    .raddr(m_raddr), .rdata(m_rdata)
  );

  // index arithmetic
  logic          acc;
  logic [IW-1:0] cnt_ext, lidx, ridx;
  logic          l_ok, r_ok, use_r;
  logic [SW-1:0] parent, best_idx;
  ihp_pkg::ihp_entry_t best, moving;

  assign acc      = start && !busy;
  assign cnt_ext  = IW'(count_r);
  assign lidx     = {1'b0, pos_r, 1'b1};
  assign ridx     = lidx + IW'(1);
  assign l_ok     = lidx < cnt_ext;
  assign r_ok     = ridx < cnt_ext;
  assign parent   = SW'((pos_r - SW'(1)) >> 1);
  assign use_r    = r_ok && (h_rdata.key < left_r.key);
  assign best     = use_r ? h_rdata : left_r;
  assign best_idx = use_r ? ridx[SW-1:0] : lidx[SW-1:0];
  assign moving   = '{vtx: mv_r, key: mk_r};

  assign busy = (state_r != ihp_pkg::ST_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ihp_pkg::ST_IDLE: begin
        if (acc) begin
          unique case (in_action)
            ihp_pkg::ACT_INSERT: begin
              if (!(count_r == CW'(CAPACITY) || present_r[in_vertex])) begin
                state_nxt = ihp_pkg::ST_UP_RD;
              end
            end
            ihp_pkg::ACT_EXTRACT: begin
              if (count_r != '0) begin
                state_nxt = ihp_pkg::ST_EX_ROOT;
              end
            end
            ihp_pkg::ACT_DECREASE: begin
              if (present_r[in_vertex]) begin
                state_nxt = ihp_pkg::ST_DK_MAP;
              end
            end
            default: state_nxt = ihp_pkg::ST_IDLE;
          endcase
        end
      end
      ihp_pkg::ST_EX_ROOT: state_nxt = ihp_pkg::ST_EX_LAST;
      ihp_pkg::ST_EX_LAST: state_nxt = ihp_pkg::ST_DN_RDL;
      ihp_pkg::ST_DN_RDL:  state_nxt = l_ok ? ihp_pkg::ST_DN_RDR : ihp_pkg::ST_FIN;
      ihp_pkg::ST_DN_RDR:  state_nxt = ihp_pkg::ST_DN_CMP;
      ihp_pkg::ST_DN_CMP: begin
        state_nxt = (best.key >= mk_r) ? ihp_pkg::ST_FIN : ihp_pkg::ST_DN_RDL;
      end
      ihp_pkg::ST_UP_RD: begin
        state_nxt = (pos_r == '0) ? ihp_pkg::ST_FIN : ihp_pkg::ST_UP_CMP;
      end
      ihp_pkg::ST_UP_CMP: begin
        state_nxt = (h_rdata.key <= mk_r) ? ihp_pkg::ST_FIN : ihp_pkg::ST_UP_RD;
      end
      ihp_pkg::ST_DK_MAP: state_nxt = ihp_pkg::ST_DK_KEY;
      ihp_pkg::ST_DK_KEY: begin
        if (IW'(pos_r) >= cnt_ext || dk_r > h_rdata.key) begin
          state_nxt = ihp_pkg::ST_IDLE;
        end else begin
          state_nxt = ihp_pkg::ST_UP_RD;
        end
      end
      ihp_pkg::ST_FIN: state_nxt = ihp_pkg::ST_IDLE;
      default: state_nxt = ihp_pkg::ST_IDLE;
    endcase
  end

  // datapath, memory control and results
  always_comb begin
    count_nxt   = count_r;
    present_nxt = present_r;
    pos_nxt     = pos_r;
    mv_nxt      = mv_r;
    mk_nxt      = mk_r;
    rv_nxt      = rv_r;
    rk_nxt      = rk_r;
    dv_nxt      = dv_r;
    dk_nxt      = dk_r;
    left_nxt    = left_r;
    ov_nxt      = 1'b0;
    os_nxt      = os_r;
    ovx_nxt     = ovx_r;
    okey_nxt    = okey_r;
    ocnt_nxt    = ocnt_r;
    h_we        = 1'b0;
    h_waddr     = pos_r;
    h_wdata     = moving;
    h_raddr     = '0;
    m_we        = 1'b0;
    m_waddr     = mv_r;
    m_wdata     = pos_r;
    m_raddr     = in_vertex;
    unique case (state_r)
      ihp_pkg::ST_IDLE: begin
        if (acc) begin
          rv_nxt   = '0;
          rk_nxt   = '0;
          dv_nxt   = in_vertex;
          dk_nxt   = in_key;
          ovx_nxt  = '0;
          okey_nxt = '0;
          ocnt_nxt = 9'(count_r);
          unique case (in_action)
            ihp_pkg::ACT_INSERT: begin
              if (count_r == CW'(CAPACITY) || present_r[in_vertex]) begin
                ov_nxt = 1'b1;
                os_nxt = ihp_pkg::STAT_FULL;
              end else begin
                mv_nxt    = in_vertex;
                mk_nxt    = in_key;
                pos_nxt   = SW'(count_r);
                count_nxt = count_r + CW'(1);
                present_nxt[in_vertex] = 1'b1;
              end
            end
            ihp_pkg::ACT_EXTRACT: begin
              if (count_r == '0) begin
                ov_nxt = 1'b1;
                os_nxt = ihp_pkg::STAT_EMPTY;
              end
            end
            ihp_pkg::ACT_DECREASE: begin
              if (!present_r[in_vertex]) begin
                ov_nxt = 1'b1;
                os_nxt = ihp_pkg::STAT_REFUSED;
              end
            end
            default: begin
              ov_nxt = 1'b1;
              os_nxt = ihp_pkg::STAT_REFUSED;
            end
          endcase
        end
      end
      ihp_pkg::ST_EX_ROOT: begin
        // root arrives, fetch last slot
        rv_nxt  = h_rdata.vtx;
        rk_nxt  = h_rdata.key;
        h_raddr = SW'(count_r - CW'(1));
      end
      ihp_pkg::ST_EX_LAST: begin
        mv_nxt    = h_rdata.vtx;
        mk_nxt    = h_rdata.key;
        pos_nxt   = '0;
        count_nxt = count_r - CW'(1);
        present_nxt[rv_r] = 1'b0;
      end
      ihp_pkg::ST_DN_RDL: h_raddr = lidx[SW-1:0];
      ihp_pkg::ST_DN_RDR: begin
        left_nxt = h_rdata;
        h_raddr  = ridx[SW-1:0];
      end
      ihp_pkg::ST_DN_CMP: begin
        // smaller child moves up into the hole
        if (best.key < mk_r) begin
          h_we    = 1'b1;
          h_wdata = best;
          m_we    = 1'b1;
          m_waddr = best.vtx;
          pos_nxt = best_idx;
        end
      end
      ihp_pkg::ST_UP_RD: h_raddr = parent;
      ihp_pkg::ST_UP_CMP: begin
        // larger parent moves down into the hole
        if (h_rdata.key > mk_r) begin
          h_we    = 1'b1;
          h_wdata = h_rdata;
          m_we    = 1'b1;
          m_waddr = h_rdata.vtx;
          pos_nxt = parent;
        end
      end
      ihp_pkg::ST_DK_MAP: begin
        pos_nxt = m_rdata;
        h_raddr = m_rdata;
      end
      ihp_pkg::ST_DK_KEY: begin
        if (IW'(pos_r) >= cnt_ext || dk_r > h_rdata.key) begin
          ov_nxt = 1'b1;
          os_nxt = ihp_pkg::STAT_REFUSED;
        end else begin
          mv_nxt = dv_r;
          mk_nxt = dk_r;
        end
      end
      ihp_pkg::ST_FIN: begin
        // settle the moving entry and report
        h_we     = 1'b1;
        m_we     = 1'b1;
        ov_nxt   = 1'b1;
        os_nxt   = ihp_pkg::STAT_OK;
        ovx_nxt  = rv_r;
        okey_nxt = rk_r;
        ocnt_nxt = 9'(count_r);
      end
      default: ov_nxt = 1'b0;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ihp_pkg::ST_IDLE;
      count_r   <= '0;
      present_r <= '0;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      present_r <= present_nxt;
      ov_r      <= ov_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pos_r  <= pos_nxt;
    mv_r   <= mv_nxt;
    mk_r   <= mk_nxt;
    rv_r   <= rv_nxt;
    rk_r   <= rk_nxt;
    dv_r   <= dv_nxt;
    dk_r   <= dk_nxt;
    left_r <= left_nxt;
    os_r   <= os_nxt;
    ovx_r  <= ovx_nxt;
    okey_r <= okey_nxt;
    ocnt_r <= ocnt_nxt;
  end

  assign out_valid  = ov_r;
  assign out_status = os_r;
  assign out_vertex = ovx_r;
  assign out_key    = okey_r;
  assign out_count  = ocnt_r;

endmodule

// ----- hdl/ihp_checker.sv -----
module ihp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [1:0]  in_action,
  input logic [7:0]  in_vertex,
  input logic [31:0] in_key,
  input logic        out_valid,
  input logic [1:0]  out_status,
  input logic [7:0]  out_vertex,
  input logic [31:0] out_key,
  input logic [8:0]  out_count
);

  // a result leaves the block ready for the next command
  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result while busy");

  // only a successful extract carries a vertex and key
  a_zero_pay: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ihp_pkg::STAT_OK) |-> (out_vertex == 8'd0 && out_key == '0))
    else $error("payload on refused command");

  // empty status only when the heap is empty
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ihp_pkg::STAT_EMPTY) |-> (out_count == 9'd0))
    else $error("empty status with nonzero count");

  // unknown action is refused at once
  a_unknown: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_action == 2'd3)
      |=> (out_valid && out_status == ihp_pkg::STAT_REFUSED))
    else $error("unknown action not refused");

  // count never exceeds the vertex range
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_count <= 9'd256)) else $error("count out of range");

endmodule

bind indexed_min_heap_top ihp_checker u_ihp_checker (.*);
